/* design/bphr_pkg.sv */
package bphr_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HOLD      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INITIAL   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RELEASE   = 3'd4;

    localparam logic [7:0]  THRESHOLD_RST = 8'd0;
    localparam logic [15:0] HOLD_RST      = 16'd0;
    localparam logic [15:0] INITIAL_RST   = 16'd30;
    localparam logic [15:0] REPEAT_RST    = 16'd6;
    localparam logic [15:0] RELEASE_RST   = 16'hFFFF;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 40;

endpackage

/* design/button_press_hold_repeat_qualifier.sv */
// Each input word is processed to completion before the next is taken: o_s_tready
// is low while the serial remainder unit works, one dividend bit per cycle, and
// while the result waits to enter the output register.
// Input is taken while an earlier output word still waits in the output register.
// Reset: synchronous, active low; clears all tick state and the output valid flag,
// and loads the register defaults.
module button_press_hold_repeat_qualifier
    import bphr_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [7:0] level
    input  logic                  i_s_tuser,   // [0] cmd (1 = clear)
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [0] clicked, [1] held, [2] pulsed, [3] released,
    // [19:4] active_count, [35:20] inactive_count, [39:36] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int CNT_W = $clog2(COUNT_WIDTH);

    t_state                 r_state, n_state;
    logic [7:0]             r_thr;
    logic [15:0]            r_hold, r_init, r_rep, r_lim;
    logic [7:0]             r_cur, n_cur, r_prev, n_prev;
    logic [COUNT_WIDTH-1:0] r_act, n_act, r_pact, n_pact, r_inact, n_inact;
    logic [COUNT_WIDTH-1:0] r_dvd, n_dvd;
    logic [15:0]            r_rem, n_rem, r_period, n_period;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]  r_out_data, n_out_data;

    logic [16:0]            w_trial;
    logic                   w_ge;
    logic [EXT_W-1:0]       w_act_ext;
    logic [31:0]            w_act32, w_inact32;
    logic                   w_above, w_was, w_clicked, w_held, w_pulsed, w_released;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THRESHOLD_RST;
            r_hold <= HOLD_RST;
            r_init <= INITIAL_RST;
            r_rep  <= REPEAT_RST;
            r_lim  <= RELEASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_THRESHOLD: r_thr  <= i_cfg_wdata[7:0];
                REG_HOLD:      r_hold <= i_cfg_wdata;
                REG_INITIAL:   r_init <= i_cfg_wdata;
                REG_REPEAT:    r_rep  <= i_cfg_wdata;
                REG_RELEASE:   r_lim  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_prev      <= '0;
            r_act       <= '0;
            r_pact      <= '0;
            r_inact     <= '0;
            r_period    <= 16'd1;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_prev      <= n_prev;
            r_act       <= n_act;
            r_pact      <= n_pact;
            r_inact     <= n_inact;
            r_period    <= n_period;
            r_rem       <= n_rem;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_out_data <= n_out_data;
    end

    // compare/subtract step of the remainder unit
    always_comb begin
        w_trial = {r_rem, r_dvd[COUNT_WIDTH-1]};
        w_ge    = w_trial >= {1'b0, r_period};
    end

    always_comb begin
        w_act_ext  = EXT_W'(r_act);
        w_act32    = 32'(r_act);
        w_inact32  = 32'(r_inact);
        w_above    = r_cur > r_thr;
        w_was      = r_prev > r_thr;
        w_clicked  = w_above && !w_was;
        w_held     = w_above && (w_act_ext >= EXT_W'(r_hold));
        w_released = !w_above && w_was && (w_act_ext <= EXT_W'(r_lim));
        w_pulsed   = w_clicked || (w_above && (r_pact != '0) && (r_act != r_pact)
                     && (r_rem == '0));
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_act       = r_act;
        n_pact      = r_pact;
        n_inact     = r_inact;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_period    = r_period;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_s_tready  = (r_state == S_IDLE);

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_s_tuser) begin
                        n_cur   = '0;
                        n_prev  = '0;
                        n_act   = '0;
                        n_pact  = '0;
                        n_inact = '0;
                    end else begin
                        n_prev = r_cur;
                        n_cur  = i_s_tdata;
                        if (i_s_tdata != '0 && r_cur == '0) begin
                            n_pact  = '0;
                            n_act   = '0;
                            n_inact = (r_inact == '1) ? r_inact
                                                      : r_inact + COUNT_WIDTH'(1);
                        end else if (i_s_tdata != '0 || r_cur != '0) begin
                            n_pact  = r_act;
                            n_inact = '0;
                            n_act   = (r_act == '1) ? r_act : r_act + COUNT_WIDTH'(1);
                        end else begin
                            n_pact  = '0;
                            n_act   = '0;
                            n_inact = (r_inact == '1) ? r_inact
                                                      : r_inact + COUNT_WIDTH'(1);
                        end
                    end
                    n_period = (EXT_W'(n_act) > EXT_W'(r_init)) ? r_rep : r_init;
                    if (n_period == '0) begin
                        n_period = 16'd1;
                    end
                    n_dvd    = n_act;
                    n_rem    = '0;
                    n_cnt    = CNT_W'(COUNT_WIDTH - 1);
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_ge ? 16'(w_trial - {1'b0, r_period}) : w_trial[15:0];
                n_dvd = {r_dvd[COUNT_WIDTH-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0, w_inact32[15:0], w_act32[15:0],
                                   w_released, w_pulsed, w_held, w_clicked};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while remainder unit busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_period))
        else $error("remainder not below period");

    a_period_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period != '0)
        else $error("zero period");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pact != '0) && (r_act != r_pact)) |-> (r_act == r_pact + COUNT_WIDTH'(1)))
        else $error("active count not one past previous");

endmodule

/* tb/tb_top.sv */
module tb_top;
    import bphr_pkg::*;

    localparam int COUNT_W = 16;
    localparam int DRAIN_CYCLES = COUNT_W + 8;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic        clicked;
        logic        held;
        logic        pulsed;
        logic        released;
        logic [15:0] act_cnt;
        logic [15:0] inact_cnt;
    } qual_t;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;   // [7:0] level
    logic                  i_s_tuser   = 1'b0; // [0] cmd (1 = clear)
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    // [0] clicked, [1] held, [2] pulsed, [3] released,
    // [19:4] active_count, [35:20] inactive_count, [39:36] zero
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // predictor copy of the registers and tick state
    logic [7:0]  thr_r  = THRESHOLD_RST;
    logic [15:0] hold_r = HOLD_RST;
    logic [15:0] init_r = INITIAL_RST;
    logic [15:0] rep_r  = REPEAT_RST;
    logic [15:0] rel_r  = RELEASE_RST;
    logic [7:0]  cur_lvl = '0;
    logic [7:0]  prev_lvl = '0;
    logic [15:0] act_ticks = '0;
    logic [15:0] pact_ticks = '0;
    logic [15:0] inact_ticks = '0;

    qual_t pending_quals[$];
    int    errors = 0;
    bit    idle_en = 1'b1;
    int    stall_left = 0;

    button_press_hold_repeat_qualifier #(.COUNT_WIDTH(COUNT_W)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic qual_t qualify_tick(input logic clr, input logic [7:0] lvl);
        qual_t       r;
        logic        above;
        logic        was_above;
        logic [15:0] period;
        if (clr) begin
            cur_lvl = '0;
            prev_lvl = '0;
            act_ticks = '0;
            pact_ticks = '0;
            inact_ticks = '0;
        end else begin
            prev_lvl = cur_lvl;
            cur_lvl = lvl;
            if (cur_lvl != 0 && prev_lvl == 0) begin
                pact_ticks = '0;
                act_ticks = '0;
                inact_ticks = bump(inact_ticks);
            end else if (cur_lvl != 0 || prev_lvl != 0) begin
                pact_ticks = act_ticks;
                inact_ticks = '0;
                act_ticks = bump(act_ticks);
            end else begin
                pact_ticks = '0;
                act_ticks = '0;
                inact_ticks = bump(inact_ticks);
            end
        end
        above = cur_lvl > thr_r;
        was_above = prev_lvl > thr_r;
        r.clicked = above && !was_above;
        r.held = above && act_ticks >= hold_r;
        r.released = !above && was_above && act_ticks <= rel_r;
        r.pulsed = r.clicked;
        if (!r.pulsed && above && pact_ticks != 0 && act_ticks != pact_ticks) begin
            period = (act_ticks > init_r) ? rep_r : init_r;
            if (period == 0) period = 16'd1;
            r.pulsed = (act_ticks / period) > (pact_ticks / period);
        end
        r.act_cnt = act_ticks;
        r.inact_cnt = inact_ticks;
        return r;
    endfunction

    // result side: random stall bursts, compare against oldest prediction
    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        qual_t q;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_quals.size() == 0) begin
                    $display("%0t: unexpected word, expected none, got %h", $time, o_m_tdata);
                    errors++;
                end else begin
                    q = pending_quals.pop_front();
                    check_field("clicked", q.clicked, o_m_tdata[0]);
                    check_field("held", q.held, o_m_tdata[1]);
                    check_field("pulsed", q.pulsed, o_m_tdata[2]);
                    check_field("released", q.released, o_m_tdata[3]);
                    check_field("active_count", q.act_cnt, o_m_tdata[19:4]);
                    check_field("inactive_count", q.inact_cnt, o_m_tdata[35:20]);
                    check_field("pad", 16'd0, o_m_tdata[39:36]);
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_m_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 3);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic clr, input logic [7:0] lvl);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= lvl;
        i_s_tuser <= clr;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_quals.push_back(qualify_tick(clr, lvl));
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (pending_quals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_THRESHOLD: thr_r = data[7:0];
            REG_HOLD:      hold_r = data;
            REG_INITIAL:   init_r = data;
            REG_REPEAT:    rep_r = data;
            REG_RELEASE:   rel_r = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] level_above();
        return (thr_r == 8'hFF) ? 8'hFF : 8'($urandom_range(thr_r + 1, 255));
    endfunction

    function automatic logic [7:0] level_below();
        if (thr_r == 0 || $urandom_range(0, 2) != 0) return 8'd0;
        return 8'($urandom_range(1, thr_r));
    endfunction

    task automatic randomize_regs();
        logic [7:0] thr;
        wait_drain();
        case ($urandom_range(0, 3))
            0: thr = 8'd0;
            1: thr = 8'($urandom_range(0, 255));
            default: thr = 8'($urandom_range(0, 40));
        endcase
        write_reg(REG_THRESHOLD, {8'($urandom_range(0, 255)), thr});
        write_reg(REG_HOLD, 16'($urandom_range(0, 50)));
        write_reg(REG_INITIAL, 16'($urandom_range(1, 40)));
        write_reg(REG_REPEAT, 16'($urandom_range(1, 10)));
        write_reg(REG_RELEASE, ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                           : 16'($urandom_range(0, 60)));
    endtask

    task automatic test_defaults();
        send_word(1'b0, 8'd0);
        send_word(1'b0, 8'd255);
        send_word(1'b0, 8'd255);
        send_word(1'b0, 8'd1);
        send_word(1'b0, 8'd0);
        send_word(1'b0, 8'd0);
        send_word(1'b0, 8'd128);
        send_word(1'b1, 8'd255);
        send_word(1'b0, 8'd0);
        send_word(1'b0, 8'd254);
        send_word(1'b0, 8'd0);
    endtask

    task automatic test_reg_extremes();
        wait_drain();
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_HOLD, 16'hFFFF);
        write_reg(REG_INITIAL, 16'hFFFF);
        write_reg(REG_REPEAT, 16'hFFFF);
        write_reg(REG_RELEASE, 16'd0);
        send_word(1'b0, 8'd255);
        send_word(1'b0, 8'd255);
        send_word(1'b0, 8'd0);
        send_word(1'b0, 8'd128);
        send_word(1'b0, 8'd0);
        wait_drain();
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_INITIAL, 16'd1);
        write_reg(REG_REPEAT, 16'd1);
        write_reg(REG_HOLD, 16'd0);
        send_word(1'b0, 8'd1);
        send_word(1'b0, 8'd2);
        send_word(1'b0, 8'd3);
        send_word(1'b0, 8'd0);
        wait_drain();
        // zero periods act as one; unknown index must not disturb anything
        write_reg(REG_INITIAL, 16'd0);
        write_reg(REG_REPEAT, 16'd0);
        write_reg(REG_UNUSED, 16'h0005);
        send_word(1'b0, 8'd9);
        send_word(1'b0, 8'd9);
        send_word(1'b0, 8'd9);
        send_word(1'b0, 8'd0);
    endtask

    task automatic run_presses(input int n);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < n) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_word($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
                    sent++;
                end
                1: begin
                    send_word(1'b1, 8'($urandom_range(0, 255)));
                    sent++;
                end
                default: begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(1, 30);
                    for (k = 0; k < len && sent < n; k++) begin
                        send_word(1'b0, level_above());
                        sent++;
                    end
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len && sent < n; k++) begin
                        send_word(1'b0, level_below());
                        sent++;
                    end
                end
            endcase
        end
    endtask

    task automatic test_random_presses();
        int ph;
        for (ph = 0; ph < 6; ph++) begin
            randomize_regs();
            run_presses(60);
        end
    endtask

    task automatic test_quiet_tail();
        randomize_regs();
        idle_en = 1'b0;
        run_presses(60);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_reg_extremes();
        test_random_presses();
        test_quiet_tail();
        wait_drain();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
